// ===== src/kucs_pkg.sv =====
// Shared types, constants and codes of the keyframe unit crossfade selector.
`timescale 1ns / 1ps
package kucs_pkg;

  localparam int FRACTION_BITS = 16;
  localparam int UNIT_BITS     = 8;
  localparam int TIME_W        = FRACTION_BITS + 1;
  localparam int DIFF_W        = TIME_W + 2;
  localparam int MAX_KEYS_DEF  = 16;

  localparam logic [TIME_W-1:0] ONE = {1'b1, {FRACTION_BITS{1'b0}}};

  localparam logic KIND_PUSH  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef logic [TIME_W-1:0]    time_t;
  typedef logic [UNIT_BITS-1:0] unit_t;

  typedef struct packed {
    logic  kind;
    time_t time_req;
    unit_t unit;
  } in_item_t;

  typedef struct packed {
    logic  push_accepted;
    unit_t back_unit;
    unit_t source_unit;
    time_t source_alpha;
    logic  back_changed;
    logic  source_changed;
  } out_item_t;

  typedef struct packed {
    time_t ktime;
    unit_t kunit;
  } key_entry_t;

  typedef struct packed {
    time_t num;
    time_t den;
  } div_req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EVAL,
    ST_DIV
  } state_t;

endpackage

// ===== src/keyframe_unit_crossfade_selector.sv =====
// Top level: key table memory, query scan, fade evaluation and result register.
`timescale 1ns / 1ps
// Keeps a cyclic schedule of up to MAX_KEYS unit keys in one key memory and
// answers pushes and queries. A push (item.kind 0) completes without leaving
// idle, and busy stays low. A query that repeats the previous time, or sees
// fewer than two keys, also completes without leaving idle. Any other query
// scans the key memory once, one key per cycle through its registered read
// port, then evaluates and, when the fade lies inside the transition, runs a
// 16-step serial divider, with busy high throughout. Each result appears on
// result for one cycle with done high, the cycle after the item ends; it
// cannot be held off. cfg_wr_en writes the transition duration and is meant
// for idle periods only.
module keyframe_unit_crossfade_selector #(
  parameter int MAX_KEYS = kucs_pkg::MAX_KEYS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  kucs_pkg::in_item_t  item,
  input  logic                cfg_wr_en,
  input  kucs_pkg::time_t     cfg_wr_data,
  output logic                done,
  output kucs_pkg::out_item_t result
);

  localparam int CW = $clog2(MAX_KEYS + 1);
  localparam int IW = $clog2(MAX_KEYS);

  // key memory
  kucs_pkg::key_entry_t key_mem [MAX_KEYS];
  kucs_pkg::key_entry_t rd_data;

  kucs_pkg::state_t state, state_next;

  logic [CW-1:0]   key_count;
  logic [CW-1:0]   rd_idx;
  logic            rd_vld;
  kucs_pkg::time_t last_time;
  kucs_pkg::time_t consec_min;
  kucs_pkg::time_t smallest_gap;
  kucs_pkg::time_t duration;
  kucs_pkg::time_t shift_half;
  logic            shifted_valid;
  kucs_pkg::time_t prev_time;
  kucs_pkg::time_t qtime;

  kucs_pkg::unit_t held_back, held_source;
  kucs_pkg::time_t held_alpha;
  logic            held_bc, held_sc;

  // scan trackers
  logic            has_above, has_below, has_any;
  kucs_pkg::time_t above_v, below_v, min_v, max_v;
  kucs_pkg::unit_t above_u, below_u, min_u, max_u;

  kucs_pkg::unit_t sel_su, sel_bu;

  // divider
  logic               div_start, div_done;
  kucs_pkg::div_req_t div_req;
  kucs_pkg::time_t    div_quo;

  kucs_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .req   (div_req),
    .done  (div_done),
    .quo   (div_quo)
  );

  // push evaluation
  logic            accept, is_push;
  kucs_pkg::time_t push_t, push_gap, new_consec;
  logic            push_ok;

  assign accept  = start && (state == kucs_pkg::ST_IDLE);
  assign is_push = item.kind == kucs_pkg::KIND_PUSH;
  assign push_t  = (item.time_req > kucs_pkg::ONE) ? kucs_pkg::ONE : item.time_req;
  assign push_ok = (key_count < CW'(MAX_KEYS)) &&
                   ((key_count == '0) || (last_time < push_t));
  assign new_consec = ((push_t - last_time) < consec_min) ? (push_t - last_time)
                                                          : consec_min;
  assign push_gap   = (key_count == '0) ? '0 : new_consec;

  logic q_repeat, q_short;
  assign q_repeat = item.time_req == prev_time;
  assign q_short  = key_count < CW'(2);

  // shifted time of the key being scanned
  kucs_pkg::time_t sh_sum, sh_v;
  assign sh_sum = rd_data.ktime + shift_half;
  assign sh_v   = (sh_sum >= kucs_pkg::ONE) ? (sh_sum - kucs_pkg::ONE) : sh_sum;

  // selection and fade evaluation
  kucs_pkg::time_t s_v;
  kucs_pkg::unit_t s_u, b_u;
  logic signed [kucs_pkg::DIFF_W-1:0] t_adj, diff, d_s, num_s;
  logic            need_div;
  kucs_pkg::time_t fast_alpha;

  always_comb begin
    if (has_above) begin
      s_v = above_v;
      s_u = above_u;
    end else begin
      s_v = min_v;
      s_u = min_u;
    end
    b_u = (has_above && has_below) ? below_u : max_u;
    t_adj = (s_v < qtime) ? ($signed({2'b00, qtime}) - $signed({2'b00, kucs_pkg::ONE}))
                          : $signed({2'b00, qtime});
    diff  = $signed({2'b00, s_v}) - t_adj;
    d_s   = $signed({2'b00, duration});
    num_s = d_s - diff;
    if ((s_u == b_u) || (duration == '0) || (diff >= d_s)) begin
      fast_alpha = '0;
      need_div   = 1'b0;
    end else if (diff <= 0) begin
      fast_alpha = kucs_pkg::ONE;
      need_div   = 1'b0;
    end else begin
      fast_alpha = '0;
      need_div   = 1'b1;
    end
  end

  assign div_start   = (state == kucs_pkg::ST_EVAL) && need_div;
  assign div_req.num = num_s[kucs_pkg::TIME_W-1:0];
  assign div_req.den = duration;

  // finish of a scanned query
  logic            fin_en;
  kucs_pkg::unit_t fin_su, fin_bu;
  kucs_pkg::time_t fin_alpha;

  always_comb begin
    fin_en    = 1'b0;
    fin_su    = sel_su;
    fin_bu    = sel_bu;
    fin_alpha = div_quo;
    case (state)
      kucs_pkg::ST_EVAL: begin
        fin_en    = !need_div;
        fin_su    = s_u;
        fin_bu    = b_u;
        fin_alpha = fast_alpha;
      end
      kucs_pkg::ST_DIV: begin
        fin_en = div_done;
      end
      default: begin
        fin_en = 1'b0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      kucs_pkg::ST_IDLE: begin
        if (accept && !is_push && !q_repeat && !q_short) state_next = kucs_pkg::ST_SCAN;
      end
      kucs_pkg::ST_SCAN: begin
        if ((rd_idx == key_count) && !rd_vld) state_next = kucs_pkg::ST_EVAL;
      end
      kucs_pkg::ST_EVAL: begin
        state_next = need_div ? kucs_pkg::ST_DIV : kucs_pkg::ST_IDLE;
      end
      kucs_pkg::ST_DIV: begin
        if (div_done) state_next = kucs_pkg::ST_IDLE;
      end
      default: begin
        state_next = kucs_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy = state != kucs_pkg::ST_IDLE;

  always_ff @(posedge clk) begin
    if (rst) state <= kucs_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // memory write on push, registered read during the scan
  always_ff @(posedge clk) begin
    if (accept && is_push && push_ok) begin
      key_mem[key_count[IW-1:0]] <= '{ktime: push_t, kunit: item.unit};
    end
    rd_data <= key_mem[rd_idx[IW-1:0]];
  end

  // control and held state
  always_ff @(posedge clk) begin
    if (rst) begin
      key_count     <= '0;
      consec_min    <= kucs_pkg::ONE;
      smallest_gap  <= kucs_pkg::ONE;
      duration      <= '0;
      shifted_valid <= 1'b0;
      prev_time     <= '0;
      held_back     <= '0;
      held_source   <= '0;
      held_alpha    <= '0;
      held_bc       <= 1'b1;
      held_sc       <= 1'b1;
      done          <= 1'b0;
      rd_vld        <= 1'b0;
      rd_idx        <= '0;
    end else begin
      done   <= 1'b0;
      rd_vld <= 1'b0;
      // lower the requested duration to the smallest gap
      if (cfg_wr_en) begin
        if (cfg_wr_data > kucs_pkg::ONE) begin
          duration <= (smallest_gap < kucs_pkg::ONE) ? smallest_gap : kucs_pkg::ONE;
        end else begin
          duration <= (smallest_gap < cfg_wr_data) ? smallest_gap : cfg_wr_data;
        end
      end
      if (accept) begin
        done <= 1'b1;
        if (is_push) begin
          result <= '{push_ok, '0, '0, '0, 1'b0, 1'b0};
          if (push_ok) begin
            key_count     <= key_count + 1'b1;
            last_time     <= push_t;
            shifted_valid <= 1'b0;
            smallest_gap  <= push_gap;
            if (key_count != '0) consec_min <= new_consec;
            if (duration > push_gap) duration <= push_gap;
          end
        end else if (q_repeat) begin
          // return the held selection
          done   <= 1'b1;
          result <= '{1'b0, held_back, held_source, held_alpha, held_bc, held_sc};
        end else if (q_short) begin
          prev_time   <= item.time_req;
          held_back   <= '0;
          held_source <= '0;
          held_alpha  <= '0;
          held_bc     <= held_back != '0;
          held_sc     <= held_source != '0;
          result <= '{1'b0, '0, '0, '0, held_back != '0, held_source != '0};
        end else begin
          // start the scan; build the shift once per push
          done      <= 1'b0;
          prev_time <= item.time_req;
          qtime     <= item.time_req;
          rd_idx    <= '0;
          has_any   <= 1'b0;
          has_above <= 1'b0;
          has_below <= 1'b0;
          if (!shifted_valid) begin
            shifted_valid <= 1'b1;
            shift_half    <= duration >> 1;
          end
        end
      end
      if ((state == kucs_pkg::ST_SCAN) && (rd_idx != key_count)) begin
        rd_idx <= rd_idx + 1'b1;
        rd_vld <= 1'b1;
      end
      // track extremes; ties keep the later key
      if (rd_vld) begin
        has_any <= 1'b1;
        if (!has_any || (sh_v <= min_v)) begin
          min_v <= sh_v;
          min_u <= rd_data.kunit;
        end
        if (!has_any || (sh_v >= max_v)) begin
          max_v <= sh_v;
          max_u <= rd_data.kunit;
        end
        if (sh_v > qtime) begin
          if (!has_above || (sh_v <= above_v)) begin
            has_above <= 1'b1;
            above_v   <= sh_v;
            above_u   <= rd_data.kunit;
          end
        end else begin
          if (!has_below || (sh_v >= below_v)) begin
            has_below <= 1'b1;
            below_v   <= sh_v;
            below_u   <= rd_data.kunit;
          end
        end
      end
      if (state == kucs_pkg::ST_EVAL) begin
        sel_su <= s_u;
        sel_bu <= b_u;
      end
      if (fin_en) begin
        done        <= 1'b1;
        held_source <= fin_su;
        held_back   <= fin_bu;
        held_alpha  <= fin_alpha;
        held_sc     <= held_source != fin_su;
        held_bc     <= held_back != fin_bu;
        result <= '{1'b0, fin_bu, fin_su, fin_alpha,
                    held_back != fin_bu, held_source != fin_su};
      end
    end
  end

`ifndef SYNTHESIS
  a_push_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (item.kind == kucs_pkg::KIND_PUSH)) |=> done)
    else $error("push did not complete in one cycle");

  a_alpha_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.source_alpha <= kucs_pkg::ONE))
    else $error("fade weight above one");

  a_push_result_clean: assert property (@(posedge clk) disable iff (rst)
    (done && result.push_accepted) |-> ((result.source_alpha == '0) &&
      (result.back_unit == '0) && (result.source_unit == '0)))
    else $error("push result carries selection data");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    key_count <= CW'(MAX_KEYS))
    else $error("key count beyond table size");
`endif

endmodule

// ===== src/kucs_div.sv =====
// Serial restoring divider for the fade weight: floor(num * ONE / den), num < den.
`timescale 1ns / 1ps
module kucs_div (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  kucs_pkg::div_req_t req,
  output logic             done,
  output kucs_pkg::time_t  quo
);

  localparam int STEP_W = $clog2(kucs_pkg::FRACTION_BITS + 1);

  logic                        run;
  logic [STEP_W-1:0]           step;
  logic [kucs_pkg::TIME_W:0]   rem;
  kucs_pkg::time_t             den;
  logic [kucs_pkg::TIME_W:0]   rem_sh;
  logic                        fits;

  // shift in one zero bit and try the subtract
  assign rem_sh = {rem[kucs_pkg::TIME_W-1:0], 1'b0};
  assign fits   = rem_sh >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run  <= 1'b1;
        step <= '0;
        rem  <= {1'b0, req.num};
        den  <= req.den;
        quo  <= '0;
      end else if (run) begin
        rem  <= fits ? (rem_sh - {1'b0, den}) : rem_sh;
        quo  <= {quo[kucs_pkg::TIME_W-2:0], fits};
        step <= step + 1'b1;
        if (step == STEP_W'(kucs_pkg::FRACTION_BITS - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
